@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that carry checks.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/srt_pkg.sv @@
// Shared types and constants for the sorted rank table.
// No dependencies; imported by srt_ctrl, sorted_rank_table, rank_checker and testbench.
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_BITS     = 16;
    localparam int KEY_W       = 31;
    localparam int RANK_W      = 7;
    localparam int ID_FIELD_W  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W       = KEY_W + ID_BITS;
    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               action;
        logic [ID_BITS-1:0] id;
        logic [KEY_W-1:0]   key;
        logic               shown;
    } cmd_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              table_full;
    } res_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] fill;
    } stat_t;

endpackage

@@ rtl/srt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/srt_ctrl.sv @@
// Sequencer for the sorted rank table: one compare unit walks the table
// through the entry RAM. Depends on srt_pkg and srt_ram.
module srt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  srt_pkg::cmd_t  cmd,
    output srt_pkg::stat_t stat,
    output logic           res_valid,
    input  logic           res_ready,
    output srt_pkg::res_t  res
);
    import srt_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              found_reg, found_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              full_reg, full_next;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ENT_W-1:0]  wdata;
    logic [IDX_W-1:0]  raddr;
    logic [ENT_W-1:0]  rdata;

    logic [KEY_W-1:0]   ent_key;
    logic [ID_BITS-1:0] ent_id;
    logic [ENT_W-1:0]   new_ent;
    logic               key_less;
    logic               id_hit;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   pos_inc;

    // entry layout: key above id
    srt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // shared compare unit
    assign ent_key  = rdata[ENT_W-1:ID_BITS];
    assign ent_id   = rdata[ID_BITS-1:0];
    assign new_ent  = {cmd_reg.key, cmd_reg.id};
    assign key_less = ent_key < cmd_reg.key;
    assign id_hit   = ent_id == cmd_reg.id;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;
    assign pos_inc  = pos_reg + 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        rank_reg <= rank_next;
        full_reg <= full_next;
    end

    // next state and RAM port
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        found_next = found_reg;
        rank_next  = rank_reg;
        full_next  = full_reg;
        we         = 1'b0;
        waddr      = cnt_reg[IDX_W-1:0];
        wdata      = rdata;
        raddr      = cnt_reg[IDX_W-1:0];
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    rank_next  = '0;
                    full_next  = 1'b0;
                    found_next = 1'b0;
                    if (cmd.action == ACT_INSERT)
                    begin
                        cnt_next = fill_reg;
                        if (!cmd.shown)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (fill_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            full_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                if (cmd_reg.action == ACT_INSERT)
                begin
                    // insert walks upward from the bottom of the table
                    if (cnt_reg == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = new_ent;
                        rank_next  = RANK_W'(1);
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        raddr      = cnt_dec[IDX_W-1:0];
                        state_next = ST_EVAL;
                    end
                end
                else
                begin
                    // remove walks downward from the top
                    if (cnt_reg == fill_reg)
                    begin
                        if (found_reg)
                        begin
                            rank_next = RANK_W'(pos_inc);
                            fill_next = fill_reg - 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end

            ST_EVAL:
            begin
                if (cmd_reg.action == ACT_INSERT)
                begin
                    we = 1'b1;
                    if (key_less)
                    begin
                        // smaller key moves down one slot
                        cnt_next   = cnt_dec;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        wdata      = new_ent;
                        rank_next  = RANK_W'(cnt_inc);
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        // close the gap behind the removed entry
                        we    = 1'b1;
                        waddr = cnt_dec[IDX_W-1:0];
                    end
                    else if (id_hit)
                    begin
                        found_next = 1'b1;
                        pos_next   = cnt_reg;
                    end
                    cnt_next   = cnt_inc;
                    state_next = ST_READ;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.idle      = state_reg == ST_IDLE;
    assign stat.fill      = fill_reg;
    assign res.rank       = rank_reg;
    assign res.table_full = full_reg;

endmodule

@@ rtl/sorted_rank_table.sv @@
// Top level of the sorted rank table: stream ports, field unpacking and
// the result register. Depends on srt_pkg, srt_ctrl and assert_macros.svh.
//
//  channel   dir  tdata                          tuser
//  s_axis    in   entry_id[15:0], strength[46:16] action[0], shown[1]
//  m_axis    out  rank[6:0]                      table_full[0]
//
// One transfer in gives one transfer out. Insert and remove step through the
// stored entries; each table step is a RAM read and a compare/write, so the
// single RAM read port sets the pace.
// A hidden or full insert skips the table walk. No item is taken while one
// is in flight; a stalled result holds in the output register, and the next
// item is taken as soon as the result has been moved there.
// Reset (rst_n low, asynchronous) empties the table; no clearing pass.
`include "assert_macros.svh"

module sorted_rank_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_id[15:0], strength[46:16], zero[47]
    input  logic [srt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[0], shown[1]
    input  logic [srt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rank[6:0], zero[7]
    output logic [srt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // table_full[0]
    output logic                           m_axis_tuser
);
    import srt_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    logic  res_valid;
    logic  res_ready;

    logic              out_valid_reg, out_valid_next;
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic              out_full_reg, out_full_next;

    // unpack input fields
    assign cmd.action = s_axis_tuser[0];
    assign cmd.shown  = s_axis_tuser[1];
    assign cmd.id     = ID_BITS'(s_axis_tdata[ID_FIELD_W-1:0]);
    assign cmd.key    = s_axis_tdata[ID_FIELD_W +: KEY_W];

    assign s_axis_tready = stat.idle;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(s_axis_tvalid),
        .cmd      (cmd),
        .stat     (stat),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // result register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_full_next  = out_full_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_rank_next  = res.rank;
            out_full_next  = res.table_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rank_reg <= out_rank_next;
        out_full_reg <= out_full_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_rank_reg);
    assign m_axis_tuser  = out_full_reg;

    // checks
    `ASSERT_ALWAYS(a_fill_bound, stat.fill <= CNT_W'(TABLE_DEPTH), "fill count past depth")
    `ASSERT_IMPL(a_full_no_rank, m_axis_tvalid && m_axis_tuser, out_rank_reg == '0, "full with rank")
    `ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready while busy")
    `ASSERT_NEXT(a_idle_fill_stable, stat.idle, $stable(stat.fill), "fill changed while idle")

endmodule

@@ tb/sv/rank_checker.sv @@
// Scoreboard for the sorted rank table: watches both stream channels, keeps
// a shadow copy of the table and compares every returned rank and full flag.
// Depends on srt_pkg.
module rank_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // entry_id[15:0], strength[46:16], zero[47]
    input  logic [srt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[0], shown[1]
    input  logic [srt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rank[6:0], zero[7]
    input  logic [srt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // table_full[0]
    input  logic                           m_axis_tuser,
    output int                             error_count,
    output int                             pending,
    output int                             checked,
    output int                             full_refusals
);
    import srt_pkg::*;

    // shadow table, descending key order; only the first shadow_fill are live
    logic [KEY_W-1:0]   shadow_key [TABLE_DEPTH];
    logic [ID_BITS-1:0] shadow_id  [TABLE_DEPTH];
    int                 shadow_fill;

    res_t rank_due[$];
    int   errs;
    int   n_checked;
    int   n_full;

    // place an entry after every stored key that is equal or greater
    function automatic res_t table_insert(logic [ID_BITS-1:0] id, logic [KEY_W-1:0] key,
                                          logic shown);
        res_t r;
        int   pos;
        r = '0;
        if (!shown)
            return r;
        if (shadow_fill >= TABLE_DEPTH)
        begin
            r.table_full = 1'b1;
            return r;
        end
        pos = 0;
        while (pos < shadow_fill && shadow_key[pos] >= key)
            pos++;
        for (int i = shadow_fill; i > pos; i--)
        begin
            shadow_key[i] = shadow_key[i-1];
            shadow_id[i]  = shadow_id[i-1];
        end
        shadow_key[pos] = key;
        shadow_id[pos]  = id;
        shadow_fill++;
        r.rank = RANK_W'(pos + 1);
        return r;
    endfunction

    // drop the topmost entry with a matching id and close the gap
    function automatic res_t table_remove(logic [ID_BITS-1:0] id);
        res_t r;
        int   pos;
        r   = '0;
        pos = 0;
        while (pos < shadow_fill && shadow_id[pos] != id)
            pos++;
        if (pos >= shadow_fill)
            return r;
        for (int i = pos; i + 1 < shadow_fill; i++)
        begin
            shadow_key[i] = shadow_key[i+1];
            shadow_id[i]  = shadow_id[i+1];
        end
        shadow_fill--;
        r.rank = RANK_W'(pos + 1);
        return r;
    endfunction

    // compare results first, then queue the prediction for a new command
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            shadow_fill = 0;
            rank_due.delete();
            errs      = 0;
            n_checked = 0;
            n_full    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.rank       = m_axis_tdata[RANK_W-1:0];
                got.table_full = m_axis_tuser;
                n_checked++;
                if (rank_due.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result, rank %0d table_full %0b",
                             $time, got.rank, got.table_full);
                end
                else
                begin
                    want = rank_due.pop_front();
                    if (got.rank !== want.rank)
                    begin
                        errs++;
                        $display("%0t: rank mismatch, expected %0d actual %0d",
                                 $time, want.rank, got.rank);
                    end
                    if (got.table_full !== want.table_full)
                    begin
                        errs++;
                        $display("%0t: table_full mismatch, expected %0b actual %0b",
                                 $time, want.table_full, got.table_full);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == ACT_REMOVE)
                    want = table_remove(s_axis_tdata[ID_BITS-1:0]);
                else
                    want = table_insert(s_axis_tdata[ID_BITS-1:0],
                                        s_axis_tdata[ID_FIELD_W +: KEY_W],
                                        s_axis_tuser[1]);
                if (want.table_full)
                    n_full++;
                rank_due.insert(rank_due.size(), want);
            end
        end
        error_count   <= errs;
        pending       <= rank_due.size();
        checked       <= n_checked;
        full_refusals <= n_full;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sorted rank table testbench: clock, reset, command stimulus,
// result-side backpressure and the verdict. Depends on srt_pkg,
// rank_checker and the sorted_rank_table RTL.
module testbench;

    import srt_pkg::*;

    localparam int POOL_SIZE   = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 140;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int error_count;
    int pending;
    int checked;
    int full_refusals;

    int                 items_sent;
    int                 quiet_cycles;
    bit                 hold_request;
    bit                 sender_no_gaps;
    bit                 sink_always_ready;
    logic [ID_BITS-1:0] id_pool [POOL_SIZE];

    sorted_rank_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rank_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending       (pending),
        .checked       (checked),
        .full_refusals (full_refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // offer one command and hold it until the transfer
    task automatic send_entry(logic act, logic [ID_BITS-1:0] id, logic [KEY_W-1:0] key,
                              logic shown);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key, id};
        s_axis_tuser  <= {shown, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (!sender_no_gaps)
            pause_sender(pick_gap());
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random command; ids mostly from a small pool so removes find matches
    task automatic random_entry(int insert_pct);
        logic               act;
        logic [ID_BITS-1:0] id;
        logic [KEY_W-1:0]   key;
        logic               shown;
        int                 sel;
        act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
        if ($urandom_range(9) < 8)
            id = id_pool[$urandom_range(POOL_SIZE - 1)];
        else
            id = ID_BITS'($urandom);
        sel = $urandom_range(9);
        if (sel < 3)
            key = KEY_W'($urandom_range(7));
        else if (sel == 3)
            key = $urandom_range(1) ? '1 : '0;
        else
            key = KEY_W'($urandom);
        shown = ($urandom_range(9) != 0);
        send_entry(act, id, key, shown);
    endtask

    // result side: ready bursts and gaps, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = sink_always_ready ? 0 : pick_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("tb: failure");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        items_sent        = 0;
        hold_request      = 1'b0;
        sender_no_gaps    = 1'b0;
        sink_always_ready = 1'b0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_BITS'($urandom);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, equal keys, duplicates, ignored fields
        send_entry(ACT_REMOVE, 16'h0042, 31'd5, 1'b1);      // nothing to remove
        send_entry(ACT_INSERT, 16'h0001, '1, 1'b0);         // hidden insert
        send_entry(ACT_INSERT, 16'hFFFF, '1, 1'b1);         // largest key
        send_entry(ACT_INSERT, 16'h0000, '0, 1'b1);         // smallest key
        send_entry(ACT_INSERT, 16'h5555, 31'd1000, 1'b1);
        send_entry(ACT_INSERT, 16'hAAAA, 31'd1000, 1'b1);   // equal key lands after
        send_entry(ACT_INSERT, 16'h5555, 31'd2000, 1'b1);   // duplicate id
        send_entry(ACT_INSERT, 16'h1234, '0, 1'b1);         // equal to the bottom key
        send_entry(ACT_INSERT, 16'h4321, '1, 1'b1);         // equal to the top key
        send_entry(ACT_REMOVE, 16'h5555, '0, 1'b1);         // topmost duplicate
        send_entry(ACT_REMOVE, 16'h5555, '0, 1'b1);         // the other one
        send_entry(ACT_REMOVE, 16'hAAAA, '1, 1'b0);         // key and shown ignored
        send_entry(ACT_REMOVE, 16'h9999, '1, 1'b1);         // no match
        send_entry(ACT_REMOVE, 16'hFFFF, '0, 1'b0);         // top entry
        send_entry(ACT_REMOVE, 16'h1234, '0, 1'b1);         // bottom entry
        send_entry(ACT_INSERT, 16'h7E7E, '0, 1'b0);         // hidden, zero key
        drain_results();

        // long result-side hold-off while commands keep coming
        hold_request   = 1'b1;
        sender_no_gaps = 1'b1;
        repeat (40) random_entry(60);
        sender_no_gaps = 1'b0;
        repeat (100) random_entry(55);
        drain_results();

        // insert-heavy: fill the table and run into the full case
        sender_no_gaps    = 1'b1;
        sink_always_ready = 1'b1;
        repeat (60) random_entry(90);
        sender_no_gaps    = 1'b0;
        sink_always_ready = 1'b0;
        repeat (70) random_entry(90);
        drain_results();

        // remove-heavy: empty it again
        repeat (120) random_entry(15);
        drain_results();

        // mixed
        repeat (60) random_entry(50);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d commands sent, %0d results checked, %0d refused on a full table",
                 items_sent, checked, full_refusals);
        $display("tb: phases covered empty, filling, full, draining and a long output stall");
        if (error_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_ram.sv
rtl/srt_ctrl.sv
rtl/sorted_rank_table.sv
tb/sv/rank_checker.sv
tb/sv/testbench.sv
